// ===== src/msbs_pkg.sv =====
// ----------------------------------------------------------------------------
// msbs_pkg
// Shared types and field widths of the multi-signature byte scanner.
// ----------------------------------------------------------------------------
package msbs_pkg;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_BYTE = 2'd0,
    CMD_SET_LENGTH = 2'd1,
    CMD_NEW_BUFFER = 2'd2,
    CMD_SCAN       = 2'd3
  } cmd_e;

endpackage

// ===== src/msbs_stream_if.sv =====
// ----------------------------------------------------------------------------
// msbs stream interfaces
// Valid/ready channels for command items and match result items.
// ----------------------------------------------------------------------------
interface msbs_in_if;
  logic                             valid;
  logic                             ready;
  msbs_pkg::cmd_e                   command;
  logic [msbs_pkg::SLOT_W-1:0]      slot;
  logic [msbs_pkg::POS_W-1:0]       byte_position;
  logic [msbs_pkg::LEN_W-1:0]       sig_length;
  logic [msbs_pkg::BYTE_W-1:0]      data_byte;

  modport source (output valid, command, slot, byte_position, sig_length, data_byte,
                  input ready);
  modport sink   (input valid, command, slot, byte_position, sig_length, data_byte,
                  output ready);
endinterface

interface msbs_out_if;
  logic                             valid;
  logic                             ready;
  logic [msbs_pkg::SLOT_W-1:0]      match_slot;
  logic [msbs_pkg::OFFSET_W-1:0]    start_offset;
  logic [msbs_pkg::LEN_W-1:0]       match_length;
  logic                             last_match;

  modport source (output valid, match_slot, start_offset, match_length, last_match,
                  input ready);
  modport sink   (input valid, match_slot, start_offset, match_length, last_match,
                  output ready);
endinterface

// ===== src/msbs_sig_mem.sv =====
// ----------------------------------------------------------------------------
// msbs_sig_mem
// Signature store: one row per slot, byte-lane writes, registered row read.
// ----------------------------------------------------------------------------
module msbs_sig_mem #(
  parameter int SLOTS         = 16,
  parameter int MAX_SIG_BYTES = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr_i,
  input  logic [$clog2(MAX_SIG_BYTES)-1:0]            wpos_i,
  input  logic [7:0]                                  wdata_i,
  input  logic                                        re_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr_i,
  output logic [MAX_SIG_BYTES*8-1:0]                  rdata_o
);

  localparam int ROW_W = MAX_SIG_BYTES * 8;

  logic [ROW_W-1:0] mem_q [SLOTS];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][{wpos_i, 3'b000} +: 8] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/msbs_history.sv =====
// ----------------------------------------------------------------------------
// msbs_history
// History window of the latest scanned bytes and the buffer byte count.
// ----------------------------------------------------------------------------
module msbs_history #(
  parameter int MAX_SIG_BYTES = 64,
  parameter int BUFFER_BYTES  = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 scan_i,
  input  logic                                 clear_i,
  input  logic [7:0]                           byte_i,
  output logic [MAX_SIG_BYTES*8-1:0]           hist_o,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]    count_o,
  output logic                                 full_o
);

  localparam int ROW_W = MAX_SIG_BYTES * 8;
  localparam int CW    = $clog2(BUFFER_BYTES + 1);

  logic [ROW_W-1:0] hist_q, hist_d;
  logic [CW-1:0]    count_q, count_d;
  logic             full;

  assign full = (count_q == CW'(BUFFER_BYTES));

  always_comb begin
    hist_d  = hist_q;
    count_d = count_q;
    if (clear_i) begin
      hist_d  = '0;
      count_d = '0;
    end else if (scan_i && !full) begin
      // newest byte enters at the top lane
      hist_d  = {byte_i, hist_q[ROW_W-1:8]};
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      count_q <= '0;
    end else begin
      hist_q  <= hist_d;
      count_q <= count_d;
    end
  end

  assign hist_o  = hist_q;
  assign count_o = count_q;
  assign full_o  = full;

endmodule

// ===== src/msbs_matcher.sv =====
// ----------------------------------------------------------------------------
// msbs_matcher
// Aligns one signature row to the window tail, then compares all lanes.
// ----------------------------------------------------------------------------
module msbs_matcher #(
  parameter int MAX_SIG_BYTES = 64
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [MAX_SIG_BYTES*8-1:0]             row_i,
  input  logic [$clog2(MAX_SIG_BYTES+1)-1:0]     len_i,
  input  logic [MAX_SIG_BYTES*8-1:0]             hist_i,
  output logic                                   hit_o
);

  localparam int ROW_W = MAX_SIG_BYTES * 8;
  localparam int LW    = $clog2(MAX_SIG_BYTES + 1);

  logic [LW-1:0]            base;
  logic [ROW_W-1:0]         sig_al_d, sig_al_q;
  logic [MAX_SIG_BYTES-1:0] mask_d, mask_q;
  logic [MAX_SIG_BYTES-1:0] eq;

  // signature byte k lines up with window lane base + k
  assign base     = LW'(MAX_SIG_BYTES) - len_i;
  assign sig_al_d = row_i << {base, 3'b000};

  always_comb begin
    for (int j = 0; j < MAX_SIG_BYTES; j++) begin
      mask_d[j] = (LW'(j) >= base);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sig_al_q <= sig_al_d;
      mask_q   <= mask_d;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_SIG_BYTES; j++) begin
      eq[j] = (sig_al_q[8*j +: 8] == hist_i[8*j +: 8]);
    end
  end

  assign hit_o = &(eq | ~mask_q);

endmodule

// ===== src/multi_signature_byte_scanner.sv =====
// ----------------------------------------------------------------------------
// multi_signature_byte_scanner
// Commands 0..2 are taken without holding the input off. A scan byte holds the
// input off while one signature row is read from the store per cycle, plus
// an end beat and two pipeline stages (s1, s2); output backpressure stalls
// this, and the next scan is taken once the end beat has left s2.
// A scan's results pass through a held-result register into the output register.
// Reset clears lengths, window, count and control; the store is not cleared.
// ----------------------------------------------------------------------------
module multi_signature_byte_scanner #(
  parameter int SLOTS         = 16,
  parameter int MAX_SIG_BYTES = 64,
  parameter int BUFFER_BYTES  = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  msbs_in_if.sink         in_i,
  msbs_out_if.source      out_o
);

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW     = $clog2(MAX_SIG_BYTES);
  localparam int LW     = $clog2(MAX_SIG_BYTES + 1);
  localparam int IW     = $clog2(SLOTS + 1);
  localparam int CW     = $clog2(BUFFER_BYTES + 1);
  localparam int ROW_W  = MAX_SIG_BYTES * 8;
  localparam int SLOT_FW = msbs_pkg::SLOT_W;
  localparam int LEN_FW  = msbs_pkg::LEN_W;
  localparam int OFF_FW  = msbs_pkg::OFFSET_W;

  // input decode
  logic in_acc, slot_ok, pos_ok;
  logic wr_byte, set_len, new_buf, scan_req, scan_go;
  logic [SW-1:0] cmd_slot;
  logic [PW-1:0] cmd_pos;
  logic [LW-1:0] len_wr;

  // lengths, history
  logic [SLOTS-1:0][LW-1:0] len_q;
  logic [ROW_W-1:0]         hist;
  logic [CW-1:0]            bytes_seen;
  logic                     hist_full;

  // slot sequencer and pipeline
  logic          busy_q;
  logic          iss_act_q;
  logic [IW-1:0] iss_cnt_q;
  logic          iss_end;
  logic [SW-1:0] iss_idx;
  logic          mem_re;
  logic [ROW_W-1:0] row;
  logic          s1_vld_q, s1_end_q;
  logic [SW-1:0] s1_slot_q;
  logic [LW-1:0] s1_len_q;
  logic          s2_vld_q, s2_end_q;
  logic [SW-1:0] s2_slot_q;
  logic [LW-1:0] s2_len_q;
  logic          match_hit;

  // result path
  logic          len_ok, hit, push, out_space, adv;
  logic [CW-1:0] diff;
  logic          pend_vld_q;
  logic [SW-1:0] pend_slot_q;
  logic [OFF_FW-1:0] pend_off_q;
  logic [LW-1:0] pend_len_q;
  logic          out_vld_q;
  logic [SLOT_FW-1:0] out_slot_q;
  logic [OFF_FW-1:0]  out_off_q;
  logic [LEN_FW-1:0]  out_len_q;
  logic          out_last_q;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;
  assign slot_ok    = (32'(in_i.slot) < SLOTS);
  assign pos_ok     = (32'(in_i.byte_position) < MAX_SIG_BYTES);
  assign cmd_slot   = SW'(in_i.slot);
  assign cmd_pos    = PW'(in_i.byte_position);
  assign len_wr     = (32'(in_i.sig_length) > MAX_SIG_BYTES) ? LW'(MAX_SIG_BYTES)
                                                              : LW'(in_i.sig_length);

  assign wr_byte  = in_acc && (in_i.command == msbs_pkg::CMD_WRITE_BYTE) && slot_ok && pos_ok;
  assign set_len  = in_acc && (in_i.command == msbs_pkg::CMD_SET_LENGTH) && slot_ok;
  assign new_buf  = in_acc && (in_i.command == msbs_pkg::CMD_NEW_BUFFER);
  assign scan_req = in_acc && (in_i.command == msbs_pkg::CMD_SCAN);
  assign scan_go  = scan_req && !hist_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (set_len) begin
      len_q[cmd_slot] <= len_wr;
    end
  end

  msbs_history #(
    .MAX_SIG_BYTES (MAX_SIG_BYTES),
    .BUFFER_BYTES  (BUFFER_BYTES)
  ) u_history (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_req),
    .clear_i (new_buf),
    .byte_i  (in_i.data_byte),
    .hist_o  (hist),
    .count_o (bytes_seen),
    .full_o  (hist_full)
  );

  // one slot per beat; the beat after the last slot is the end marker
  assign iss_end = (iss_cnt_q == IW'(SLOTS));
  assign iss_idx = iss_cnt_q[SW-1:0];
  assign mem_re  = adv && iss_act_q && !iss_end;

  msbs_sig_mem #(
    .SLOTS         (SLOTS),
    .MAX_SIG_BYTES (MAX_SIG_BYTES)
  ) u_sig_mem (
    .clk_i   (clk_i),
    .we_i    (wr_byte),
    .waddr_i (cmd_slot),
    .wpos_i  (cmd_pos),
    .wdata_i (in_i.data_byte),
    .re_i    (mem_re),
    .raddr_i (iss_idx),
    .rdata_o (row)
  );

  msbs_matcher #(
    .MAX_SIG_BYTES (MAX_SIG_BYTES)
  ) u_matcher (
    .clk_i  (clk_i),
    .en_i   (adv),
    .row_i  (row),
    .len_i  (s1_len_q),
    .hist_i (hist),
    .hit_o  (match_hit)
  );

  assign len_ok    = (s2_len_q != '0) && (CW'(s2_len_q) <= bytes_seen);
  assign hit       = s2_vld_q && !s2_end_q && len_ok && match_hit;
  // a held result leaves when a later one shows up or at the end beat
  assign push      = s2_vld_q && pend_vld_q && (s2_end_q || hit);
  assign out_space = !out_vld_q || out_o.ready;
  assign adv       = !push || out_space;
  assign diff      = bytes_seen - CW'(s2_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_act_q  <= 1'b0;
      iss_cnt_q  <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (scan_go) begin
        busy_q    <= 1'b1;
        iss_act_q <= 1'b1;
        iss_cnt_q <= '0;
      end else if (adv && iss_act_q) begin
        iss_cnt_q <= iss_cnt_q + IW'(1);
        if (iss_end) begin
          iss_act_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_vld_q <= iss_act_q;
        s2_vld_q <= s1_vld_q;
        if (s2_vld_q && s2_end_q) begin
          busy_q     <= 1'b0;
          pend_vld_q <= 1'b0;
        end else if (hit) begin
          pend_vld_q <= 1'b1;
        end
      end
      if (adv && push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_end_q  <= iss_end;
      s1_slot_q <= iss_idx;
      s1_len_q  <= len_q[iss_idx];
      s2_end_q  <= s1_end_q;
      s2_slot_q <= s1_slot_q;
      s2_len_q  <= s1_len_q;
      if (hit) begin
        pend_slot_q <= s2_slot_q;
        pend_off_q  <= OFF_FW'(diff);
        pend_len_q  <= s2_len_q;
      end
      if (push) begin
        out_slot_q <= SLOT_FW'(pend_slot_q);
        out_off_q  <= pend_off_q;
        out_len_q  <= LEN_FW'(pend_len_q);
        out_last_q <= s2_end_q;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.match_slot   = out_slot_q;
  assign out_o.start_offset = out_off_q;
  assign out_o.match_length = out_len_q;
  assign out_o.last_match   = out_last_q;

endmodule

// ===== src/msbs_checker.sv =====
// ----------------------------------------------------------------------------
// msbs_checker
// Port-level checks on the scanner's command and result channels.
// ----------------------------------------------------------------------------
module msbs_checker #(
  parameter int SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  msbs_pkg::cmd_e                    in_command_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [msbs_pkg::SLOT_W-1:0]       out_slot_i,
  input  logic [msbs_pkg::OFFSET_W-1:0]     out_offset_i,
  input  logic [msbs_pkg::LEN_W-1:0]        out_length_i,
  input  logic                              out_last_i
);

  logic                         open_q;
  logic [msbs_pkg::SLOT_W-1:0]  prev_slot_q;
  logic                         out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  // track an open run of results for one scanned byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      prev_slot_q <= '0;
    end else if (out_acc) begin
      open_q      <= !out_last_i;
      prev_slot_q <= out_slot_i;
    end
  end

  a_cfg_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_command_i != msbs_pkg::CMD_SCAN) |=> in_ready_i)
    else $error("ready dropped after a non-scan item");

  a_ready_falls_on_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_command_i == msbs_pkg::CMD_SCAN))
    else $error("ready fell without a scan item");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && open_q && (SLOTS <= 16)) |-> (out_slot_i > prev_slot_q))
    else $error("results of one byte not in ascending slot order");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({out_slot_i, out_offset_i, out_length_i, out_last_i})))
    else $error("stalled result item changed");

endmodule

bind multi_signature_byte_scanner msbs_checker #(
  .SLOTS (SLOTS)
) u_msbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_slot_i   (out_o.match_slot),
  .out_offset_i (out_o.start_offset),
  .out_length_i (out_o.match_length),
  .out_last_i   (out_o.last_match)
);
